// ----- hw/rtl/ial_pkg.sv -----
// ============================================================================
// ial_pkg
// Shared widths, operation codes, status codes and command types for the
// indexed array list.
// ============================================================================
package ial_pkg;

  localparam int LIST_DEPTH    = 16;
  localparam int ELEMENT_WIDTH = 32;

  // Position and count widths follow from the depth.
  localparam int IDX_W = $clog2(LIST_DEPTH);
  localparam int CNT_W = $clog2(LIST_DEPTH + 1);

  // Field widths of the stream beats.
  localparam int FUNC_W   = 3;
  localparam int STATUS_W = 2;

  // Operation codes.
  localparam logic [FUNC_W-1:0] FN_GET    = 3'd0;
  localparam logic [FUNC_W-1:0] FN_SET    = 3'd1;
  localparam logic [FUNC_W-1:0] FN_INSERT = 3'd2;
  localparam logic [FUNC_W-1:0] FN_REMOVE = 3'd3;
  localparam logic [FUNC_W-1:0] FN_APPEND = 3'd4;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INDEX = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

  // Command from the controller to the datapath.
  typedef struct packed {
    logic exec;  // Carry out the operation on the beat at the input now.
  } ial_cmd_t;

endpackage

// ----- hw/rtl/ial_ctrl.sv -----
// ============================================================================
// ial_ctrl
// Handshake controller: takes one input beat, then holds the result beat
// until it is taken.
// ============================================================================
module ial_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  output ial_pkg::ial_cmd_t cmd
);

  typedef enum logic [1:0] {
    IDLE = 2'b01,
    RESP = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      IDLE: begin
        if (s_tvalid) begin
          state_next = RESP;
        end
      end
      RESP: begin
        if (m_tready) begin
          state_next = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == IDLE);
  assign m_tvalid = (state == RESP);
  assign cmd.exec = s_tvalid && (state == IDLE);

endmodule

// ----- hw/rtl/ial_datapath.sv -----
// ============================================================================
// ial_datapath
// List storage as a chain of word cells that shift together, the entry
// count, operation decode and the registered result.
// ============================================================================
module ial_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  ial_pkg::ial_cmd_t                    cmd,
  input  logic [ial_pkg::FUNC_W-1:0]           func,
  input  logic [ial_pkg::CNT_W-1:0]            index,
  input  logic [ial_pkg::ELEMENT_WIDTH-1:0]    element,
  output logic [ial_pkg::ELEMENT_WIDTH-1:0]    data,
  output logic [ial_pkg::STATUS_W-1:0]         status,
  output logic [ial_pkg::CNT_W-1:0]            count
);

  logic [ial_pkg::ELEMENT_WIDTH-1:0] cells [ial_pkg::LIST_DEPTH];
  logic [ial_pkg::ELEMENT_WIDTH-1:0] below_word [ial_pkg::LIST_DEPTH];
  logic [ial_pkg::ELEMENT_WIDTH-1:0] above_word [ial_pkg::LIST_DEPTH];

  logic                              in_range;
  logic [ial_pkg::CNT_W-1:0]         ins_pos;
  logic [ial_pkg::ELEMENT_WIDTH-1:0] rd_word;
  logic [ial_pkg::ELEMENT_WIDTH-1:0] data_next;
  logic [ial_pkg::STATUS_W-1:0]      status_next;
  logic                              set_ok;
  logic                              ins_ok;
  logic                              rem_ok;

  assign in_range = (index < count);
  assign ins_pos  = (func == ial_pkg::FN_APPEND) ? count : index;
  assign rd_word  = cells[index[ial_pkg::IDX_W-1:0]];

  always_comb begin
    data_next   = '0;
    status_next = ial_pkg::ST_OK;
    set_ok      = 1'b0;
    ins_ok      = 1'b0;
    rem_ok      = 1'b0;
    unique case (func)
      ial_pkg::FN_GET: begin
        if (in_range) begin
          data_next = rd_word;
        end else begin
          status_next = ial_pkg::ST_INDEX;
        end
      end
      ial_pkg::FN_SET: begin
        if (in_range) begin
          data_next = rd_word;
          set_ok    = 1'b1;
        end else begin
          status_next = ial_pkg::ST_INDEX;
        end
      end
      ial_pkg::FN_INSERT, ial_pkg::FN_APPEND: begin
        // The position test comes before the full test.
        if (ins_pos > count) begin
          status_next = ial_pkg::ST_INDEX;
        end else if (count == ial_pkg::CNT_W'(ial_pkg::LIST_DEPTH)) begin
          status_next = ial_pkg::ST_FULL;
        end else begin
          ins_ok = 1'b1;
        end
      end
      ial_pkg::FN_REMOVE: begin
        if (count == '0) begin
          status_next = ial_pkg::ST_EMPTY;
        end else if (!in_range) begin
          status_next = ial_pkg::ST_INDEX;
        end else begin
          data_next = rd_word;
          rem_ok    = 1'b1;
        end
      end
      default: begin
        status_next = ial_pkg::ST_INDEX;
      end
    endcase
  end

  // Each cell loads the new word, its lower neighbor (shift up) or its upper
  // neighbor (shift down). Cells at the ends take themselves where there is
  // no neighbor.
  for (genvar g = 0; g < ial_pkg::LIST_DEPTH; g++) begin : g_cell
    localparam logic [ial_pkg::CNT_W-1:0] POS = ial_pkg::CNT_W'(g);

    if (g == 0) begin : g_first
      assign below_word[g] = cells[g];
    end else begin : g_mid_lo
      assign below_word[g] = cells[g-1];
    end

    if (g == ial_pkg::LIST_DEPTH - 1) begin : g_last
      assign above_word[g] = cells[g];
    end else begin : g_mid_hi
      assign above_word[g] = cells[g+1];
    end

    always_ff @(posedge clk) begin
      if (cmd.exec) begin
        priority if (ins_ok && (POS == ins_pos)) begin
          cells[g] <= element;
        end else if (ins_ok && (POS > ins_pos)) begin
          cells[g] <= below_word[g];
        end else if (set_ok && (POS == index)) begin
          cells[g] <= element;
        end else if (rem_ok && (POS >= index)) begin
          cells[g] <= above_word[g];
        end else begin
          cells[g] <= cells[g];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.exec) begin
      if (ins_ok) begin
        count <= count + 1'b1;
      end else if (rem_ok) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      data   <= data_next;
      status <= status_next;
    end
  end

endmodule

// ----- hw/rtl/indexed_array_list.sv -----
// ============================================================================
// indexed_array_list
// Ordered list of up to 16 words addressed by position, with get, set,
// insert, remove and append operations and one result beat per operation.
// ============================================================================
//
//   Channel   Direction  Fields (lowest bit up)
//   s_*       in         func[2:0], index[7:3], element[39:8]
//   m_*       out        data[31:0], status[33:32], count[38:34], zero[39]
//
// The input beat is taken and the operation is carried out in the same
// cycle, and the result beat is offered from the next cycle on. The
// controller holds one operation at a time, so the next input beat is taken
// in the cycle after the result beat leaves.
// Reset clears the entry count and the controller; the stored words are
// not cleared, since no position at or above the count is ever read.
// A stall on the result side holds the result and keeps s_tready low.
//
module indexed_array_list (
  input  logic        clk,
  input  logic        rst,
  // Input beats: func, index, element.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // func[2:0], index[7:3], element[39:8]
  // Result beats: data, status, count.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // data[31:0], status[33:32], count[38:34], 0
);

  ial_pkg::ial_cmd_t cmd;

  logic [ial_pkg::FUNC_W-1:0]        func;
  logic [ial_pkg::CNT_W-1:0]         index;
  logic [ial_pkg::ELEMENT_WIDTH-1:0] element;
  logic [ial_pkg::ELEMENT_WIDTH-1:0] data;
  logic [ial_pkg::STATUS_W-1:0]      status;
  logic [ial_pkg::CNT_W-1:0]         count;

  // Unpack the input beat.
  assign func    = s_tdata[2:0];
  assign index   = s_tdata[7:3];
  assign element = s_tdata[39:8];

  // The controller only sequences the handshakes; all list state lives in
  // the datapath.
  ial_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  // The datapath registers the result of each operation, and its count
  // register already holds the count after that operation.
  ial_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .func    (func),
    .index   (index),
    .element (element),
    .data    (data),
    .status  (status),
    .count   (count)
  );

  // Pack the result beat, with the spare top bit held at zero.
  assign m_tdata = {1'b0, count, status, data};

endmodule
